FILE: sv/lfu_pkg.sv
package lfu_pkg;

   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;
   localparam int USE_W    = 32;
   localparam int STAMP_W  = 48;
   localparam int STATUS_W = 3;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_GET_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_GET_MISS    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUT_UPDATED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_PUT_FREE    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_PUT_EVICT   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_PUT_IGNORED = 3'd5;

   // Request action codes
   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Sequencer controls for the scan unit
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

   // Scan unit results
   typedef struct packed {
      logic hit;
      logic free;
      logic min_have;
   } scan_flags_type;

endpackage

FILE: sv/lfu_scan.sv
// Scan tracker: one slot per cycle, keep first key match, first free slot,
// and the valid slot with the lowest (use count, touch stamp) pair.
module lfu_scan #(
   parameter int IDX_W = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lfu_pkg::scan_ctl_type               ctl,
   input  logic [IDX_W-1:0]                    samp_idx,
   input  logic                                samp_vld,
   input  logic [lfu_pkg::KEY_W-1:0]           samp_key,
   input  logic [lfu_pkg::DATA_W-1:0]          samp_data,
   input  logic [lfu_pkg::USE_W-1:0]           samp_cnt,
   input  logic [lfu_pkg::STAMP_W-1:0]         samp_touch,
   input  logic [lfu_pkg::KEY_W-1:0]           want_key,
   output lfu_pkg::scan_flags_type             flags,
   output logic [IDX_W-1:0]                    hit_idx,
   output logic [lfu_pkg::DATA_W-1:0]          hit_data,
   output logic [lfu_pkg::USE_W-1:0]           hit_cnt,
   output logic [IDX_W-1:0]                    free_idx,
   output logic [IDX_W-1:0]                    min_idx,
   output logic [lfu_pkg::KEY_W-1:0]           min_key
);

   lfu_pkg::scan_flags_type              flags_ff;
   logic [IDX_W-1:0]                     hit_idx_ff;
   logic [lfu_pkg::DATA_W-1:0]           hit_data_ff;
   logic [lfu_pkg::USE_W-1:0]            hit_cnt_ff;
   logic [IDX_W-1:0]                     free_idx_ff;
   logic [IDX_W-1:0]                     min_idx_ff;
   logic [lfu_pkg::KEY_W-1:0]            min_key_ff;
   logic [lfu_pkg::USE_W-1:0]            min_cnt_ff;
   logic [lfu_pkg::STAMP_W-1:0]          min_touch_ff;

   logic take_hit;
   logic take_free;
   logic take_min;
   logic older;

   // Shared comparator: count first, touch stamp breaks the tie
   assign older = {samp_cnt, samp_touch} < {min_cnt_ff, min_touch_ff};

   assign take_hit  = ctl.sample && samp_vld && !flags_ff.hit && (samp_key == want_key);
   assign take_free = ctl.sample && !samp_vld && !flags_ff.free;
   assign take_min  = ctl.sample && samp_vld && (!flags_ff.min_have || older);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         flags_ff <= '0;
      end else begin
         if (take_hit)  flags_ff.hit      <= 1'b1;
         if (take_free) flags_ff.free     <= 1'b1;
         if (take_min)  flags_ff.min_have <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_hit) begin
         hit_idx_ff  <= samp_idx;
         hit_data_ff <= samp_data;
         hit_cnt_ff  <= samp_cnt;
      end
      if (take_free) begin
         free_idx_ff <= samp_idx;
      end
      if (take_min) begin
         min_idx_ff   <= samp_idx;
         min_key_ff   <= samp_key;
         min_cnt_ff   <= samp_cnt;
         min_touch_ff <= samp_touch;
      end
   end

   assign flags    = flags_ff;
   assign hit_idx  = hit_idx_ff;
   assign hit_data = hit_data_ff;
   assign hit_cnt  = hit_cnt_ff;
   assign free_idx = free_idx_ff;
   assign min_idx  = min_idx_ff;
   assign min_key  = min_key_ff;

endmodule

FILE: sv/lfu_cache_table_unit.sv
// Channel   Direction  Handshake               Word
// req       in         req_valid / req_stall   action, key, value
// rsp       out        rsp_valid / rsp_stall   status, read_value, evicted_key
// csr       in         csr_wr_en               capacity (5 bits)
//
// Sequence: a word is scanned over n slots, n = min(capacity, ENTRIES), and then
//   answered; the next word is taken only after the previous one is answered.
//   The scan reads one slot a cycle through a single shared compare unit.
// Reset: synchronous; clears slot valid bits and touch clock, sets capacity to 16.
// Stalls: the response register holds a word while rsp_stall is high; a new
//   request is accepted meanwhile and waits in its update step for the slot.
module lfu_cache_table_unit #(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic signed [31:0]  req_key,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_read_value,
   output logic signed [31:0]  rsp_evicted_key,
   input  logic                csr_wr_en,
   input  logic [4:0]          csr_wr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Control state
   lfu_pkg::state_type                 state_ff, state_in;
   logic [lfu_pkg::CAP_W-1:0]          capacity_ff;
   logic [CNT_W-1:0]                   n_ff;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic                               pend_ff, pend_in;
   logic [IDX_W-1:0]                   pend_idx_ff;
   logic [lfu_pkg::STAMP_W-1:0]        touch_clk_ff;
   logic [ENTRIES-1:0]                 vld_ff;
   logic                               rsp_valid_ff;

   // Request payload, latched on accept
   logic                               act_ff;
   logic [lfu_pkg::KEY_W-1:0]          key_ff;
   logic [lfu_pkg::DATA_W-1:0]         val_ff;

   // Response payload
   logic [lfu_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [lfu_pkg::DATA_W-1:0]         rsp_read_ff;
   logic [lfu_pkg::KEY_W-1:0]          rsp_evict_ff;

   // Slot memories and their registered read data
   logic [lfu_pkg::KEY_W-1:0]          key_mem   [ENTRIES];
   logic [lfu_pkg::DATA_W-1:0]         data_mem  [ENTRIES];
   logic [lfu_pkg::USE_W-1:0]          use_mem   [ENTRIES];
   logic [lfu_pkg::STAMP_W-1:0]        touch_mem [ENTRIES];
   logic [lfu_pkg::KEY_W-1:0]          rd_key_ff;
   logic [lfu_pkg::DATA_W-1:0]         rd_data_ff;
   logic [lfu_pkg::USE_W-1:0]          rd_cnt_ff;
   logic [lfu_pkg::STAMP_W-1:0]        rd_touch_ff;

   // Sequencer outputs
   logic                               accept;
   logic                               issue;
   logic                               out_load;
   lfu_pkg::scan_ctl_type              scan_ctl;
   logic [CNT_W-1:0]                   live;
   logic [IDX_W-1:0]                   rd_addr;

   // Update step
   logic [IDX_W-1:0]                   wr_idx;
   logic                               key_wr;
   logic                               data_wr;
   logic                               use_wr;
   logic                               touch_wr;
   logic [lfu_pkg::USE_W-1:0]          use_wd;
   logic [lfu_pkg::STATUS_W-1:0]       status_nx;
   logic [lfu_pkg::DATA_W-1:0]         read_nx;
   logic [lfu_pkg::KEY_W-1:0]          evict_nx;

   // Scan unit results
   lfu_pkg::scan_flags_type            flags;
   logic [IDX_W-1:0]                   hit_idx;
   logic [lfu_pkg::DATA_W-1:0]         hit_data;
   logic [lfu_pkg::USE_W-1:0]          hit_cnt;
   logic [IDX_W-1:0]                   free_idx;
   logic [IDX_W-1:0]                   min_idx;
   logic [lfu_pkg::KEY_W-1:0]          min_key;

   // Clamp capacity to the slot count
   assign live = (32'(capacity_ff) > 32'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(capacity_ff);

   assign req_stall = (state_ff != lfu_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = cnt_ff[IDX_W-1:0];

   // Sequencer: accept, scan one slot per cycle, then update and respond
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = 1'b0;
      issue     = 1'b0;
      out_load  = 1'b0;
      scan_ctl  = '0;
      wr_idx    = hit_idx;
      key_wr    = 1'b0;
      data_wr   = 1'b0;
      use_wr    = 1'b0;
      touch_wr  = 1'b0;
      use_wd    = '0;
      status_nx = lfu_pkg::STATUS_GET_MISS;
      read_nx   = '0;
      evict_nx  = '0;

      // Work out the update from the scan results
      if (act_ff == lfu_pkg::ACTION_GET) begin
         if (flags.hit) begin
            status_nx = lfu_pkg::STATUS_GET_HIT;
            read_nx   = hit_data;
            use_wr    = 1'b1;
            touch_wr  = 1'b1;
         end
      end else if (n_ff == '0) begin
         status_nx = lfu_pkg::STATUS_PUT_IGNORED;
      end else if (flags.hit) begin
         status_nx = lfu_pkg::STATUS_PUT_UPDATED;
         data_wr   = 1'b1;
         use_wr    = 1'b1;
         touch_wr  = 1'b1;
      end else begin
         key_wr   = 1'b1;
         data_wr  = 1'b1;
         use_wr   = 1'b1;
         touch_wr = 1'b1;
         if (flags.free) begin
            status_nx = lfu_pkg::STATUS_PUT_FREE;
            wr_idx    = free_idx;
         end else begin
            status_nx = lfu_pkg::STATUS_PUT_EVICT;
            wr_idx    = min_idx;
            evict_nx  = min_key;
         end
      end

      // Saturate the count on a bump; a fresh entry starts at one
      if (flags.hit) begin
         use_wd = (hit_cnt == '1) ? hit_cnt : hit_cnt + lfu_pkg::USE_W'(1);
      end else begin
         use_wd = lfu_pkg::USE_W'(1);
      end

      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (accept) begin
               scan_ctl.clear = 1'b1;
               cnt_in         = '0;
               state_in       = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            issue           = (cnt_ff < n_ff);
            pend_in         = issue;
            scan_ctl.sample = pend_ff;
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = lfu_pkg::ST_UPDATE;
            end
         end
         lfu_pkg::ST_UPDATE: begin
            // Hold until the response register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               out_load = 1'b1;
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase

      // Drop all writes unless the update commits this cycle
      if (!out_load) begin
         key_wr   = 1'b0;
         data_wr  = 1'b0;
         use_wr   = 1'b0;
         touch_wr = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfu_pkg::ST_IDLE;
         capacity_ff  <= lfu_pkg::CAP_RESET;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         touch_clk_ff <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (touch_wr) begin
            touch_clk_ff <= touch_clk_ff + lfu_pkg::STAMP_W'(1);
         end
         if (key_wr) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         key_ff <= req_key;
         val_ff <= req_value;
         n_ff   <= live;
      end
      if (issue) begin
         pend_idx_ff <= rd_addr;
      end
      if (out_load) begin
         rsp_status_ff <= status_nx;
         rsp_read_ff   <= read_nx;
         rsp_evict_ff  <= evict_nx;
      end
   end

   // Slot memories: one write at wr_idx, one registered read at rd_addr
   always_ff @(posedge clock) begin
      if (key_wr)   key_mem[wr_idx]   <= key_ff;
      if (data_wr)  data_mem[wr_idx]  <= val_ff;
      if (use_wr)   use_mem[wr_idx]   <= use_wd;
      if (touch_wr) touch_mem[wr_idx] <= touch_clk_ff;
      if (issue) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_data_ff  <= data_mem[rd_addr];
         rd_cnt_ff   <= use_mem[rd_addr];
         rd_touch_ff <= touch_mem[rd_addr];
      end
   end

   lfu_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .samp_idx   (pend_idx_ff),
      .samp_vld   (vld_ff[pend_idx_ff]),
      .samp_key   (rd_key_ff),
      .samp_data  (rd_data_ff),
      .samp_cnt   (rd_cnt_ff),
      .samp_touch (rd_touch_ff),
      .want_key   (key_ff),
      .flags      (flags),
      .hit_idx    (hit_idx),
      .hit_data   (hit_data),
      .hit_cnt    (hit_cnt),
      .free_idx   (free_idx),
      .min_idx    (min_idx),
      .min_key    (min_key)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_evicted_key = rsp_evict_ff;

   // A response word appears only out of the update step
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == lfu_pkg::ST_UPDATE)
      else $error("response raised outside update step");

   // The touch clock advances by at most one per cycle
   a_touch_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (touch_clk_ff == $past(touch_clk_ff)) ||
               (touch_clk_ff == $past(touch_clk_ff) + lfu_pkg::STAMP_W'(1)))
      else $error("touch clock jumped");

   // An eviction always has a victim from the scan
   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (out_load && status_nx == lfu_pkg::STATUS_PUT_EVICT) |-> flags.min_have)
      else $error("eviction without a scanned victim");

   // Slot memories change only in the update step
   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      (key_wr || data_wr || use_wr || touch_wr) |-> state_ff == lfu_pkg::ST_UPDATE)
      else $error("slot write outside update step");

   // No read is issued past the live slot count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      issue |-> (state_ff == lfu_pkg::ST_SCAN) && (cnt_ff < n_ff))
      else $error("scan read beyond live slots");

endmodule
